@@ hw/rtl/pfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM frame decoder package
// Widths, register indexes, reset values and status codes shared by the
// decoder and its channel interfaces.
// ----------------------------------------------------------------------------
package pfd_pkg;

	localparam int INTERVAL_W = 16;
	localparam int COUNT_W    = 5;
	localparam int INDEX_W    = 4;
	localparam int TICKS_W    = 8;
	localparam int ELAPSED_W  = 18;
	localparam int CFG_DATA_W = 18;
	localparam int CFG_IDX_W  = 3;

	// Largest channel count that detection accepts.
	localparam int CHAN_LIMIT = 16;

	localparam logic [INTERVAL_W-1:0] SYNC_MIN_RST        = 16'd600;
	localparam logic [INTERVAL_W-1:0] SYNC_MAX_RST        = 16'd1500;
	localparam logic [TICKS_W-1:0]    LOST_TICK_LIMIT_RST = 8'd20;
	localparam logic [ELAPSED_W-1:0]  LOST_TIME_LIMIT_RST = 18'd200000;
	localparam logic [INTERVAL_W-1:0] TICK_PERIOD_RST     = 16'd10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_MIN        = 3'd0,
		REG_SYNC_MAX        = 3'd1,
		REG_LOST_TICK_LIMIT = 3'd2,
		REG_LOST_TIME_LIMIT = 3'd3,
		REG_TICK_PERIOD     = 3'd4
	} pfd_reg_t;

	typedef enum logic [1:0] {
		LINK_OK          = 2'd0,
		LINK_LOST        = 2'd1,
		LINK_REALLY_LOST = 2'd2
	} pfd_link_t;

	typedef enum logic {
		MODE_EDGE = 1'b0,
		MODE_TICK = 1'b1
	} pfd_mode_t;

endpackage

@@ hw/rtl/pfd_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM decoder input channel
// Valid/ready channel carrying one edge interval or timeout tick per beat.
// ----------------------------------------------------------------------------
interface pfd_in_if
	import pfd_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic                  mode;
	logic [INTERVAL_W-1:0] interval;

	modport source (output valid, output mode, output interval, input ready);
	modport sink   (input valid, input mode, input interval, output ready);
endinterface

@@ hw/rtl/pfd_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM decoder result channel
// Valid/ready channel carrying one decode result per beat.
// ----------------------------------------------------------------------------
interface pfd_out_if
	import pfd_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [1:0]            link_status;
	logic                  detecting;
	logic [COUNT_W-1:0]    channel_total;
	logic                  value_valid;
	logic [INDEX_W-1:0]    channel_index;
	logic [INTERVAL_W-1:0] channel_value;
	logic                  frame_sync;

	modport source (
		output valid, output link_status, output detecting, output channel_total,
		output value_valid, output channel_index, output channel_value,
		output frame_sync, input ready
	);
	modport sink (
		input valid, input link_status, input detecting, input channel_total,
		input value_valid, input channel_index, input channel_value,
		input frame_sync, output ready
	);
endinterface

@@ hw/rtl/ppm_frame_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM frame decoder core
// Learns the channel count of an RC PPM stream and decodes channel intervals.
// ----------------------------------------------------------------------------
// Every input beat (an edge interval or a timeout tick) yields exactly one
// result beat. The decoder takes one beat per clock cycle while the result
// register is free or drains; a beat is captured in an input register, and
// then a single pass of compares and one saturating add updates the decoder
// state and loads the result register, which offers the result to the sink.
// That single state-update pass is what sets the rate: each beat depends on
// the state left by the one before it. The result register holds a finished
// beat while the sink stalls, and the input register keeps taking beats as
// long as the result register frees up. Configuration writes (sync window,
// loss limits, tick period) are meant for idle periods; after reset the
// decoder is in channel detection with zero channels and the elapsed time
// since sync saturated, so the link reports really lost.
// ----------------------------------------------------------------------------
module ppm_frame_decoder_core
	import pfd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pfd_in_if.sink                in_ch,
	pfd_out_if.source             out_ch
);

	localparam logic [COUNT_W-1:0]   MAX_CH      = COUNT_W'(CHAN_LIMIT);
	localparam logic [COUNT_W-1:0]   PULSE_SAT   = '1;
	localparam logic [TICKS_W-1:0]   TICKS_SAT   = '1;
	localparam logic [ELAPSED_W-1:0] ELAPSED_SAT = '1;

	// Configuration registers.
	logic [INTERVAL_W-1:0] sync_min_q;
	logic [INTERVAL_W-1:0] sync_max_q;
	logic [TICKS_W-1:0]    lost_tick_limit_q;
	logic [ELAPSED_W-1:0]  lost_time_limit_q;
	logic [INTERVAL_W-1:0] tick_period_q;

	// Decoder state.
	logic                  in_detect_q;
	logic [COUNT_W-1:0]    pulse_count_q;
	logic [COUNT_W-1:0]    channel_count_q;
	logic [TICKS_W-1:0]    lost_ticks_q;
	logic [ELAPSED_W-1:0]  elapsed_q;

	// Input register.
	logic                  valid_s1;
	logic                  mode_s1;
	logic [INTERVAL_W-1:0] interval_s1;

	// Result register.
	logic                  valid_s2;
	pfd_link_t             link_s2;
	logic                  detect_s2;
	logic [COUNT_W-1:0]    total_s2;
	logic                  vvalid_s2;
	logic [INDEX_W-1:0]    index_s2;
	logic [INTERVAL_W-1:0] value_s2;
	logic                  fsync_s2;

	// Next-state logic.
	logic                  advance;
	logic                  gap;
	logic [INTERVAL_W-1:0] add_term;
	logic [ELAPSED_W:0]    elapsed_sum;
	logic [ELAPSED_W-1:0]  elapsed_sat;
	logic [COUNT_W-1:0]    pulses_less_one;
	logic                  det_n;
	logic [COUNT_W-1:0]    pc_n;
	logic [COUNT_W-1:0]    cc_n;
	logic [TICKS_W-1:0]    lt_n;
	logic [ELAPSED_W-1:0]  el_n;
	logic                  vvalid_n;
	logic [INDEX_W-1:0]    index_n;
	logic [INTERVAL_W-1:0] value_n;
	logic                  fsync_n;
	pfd_link_t             link_n;

	// Move the input beat on whenever the result register is free or drains.
	assign advance     = !valid_s2 || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_min_q        <= SYNC_MIN_RST;
			sync_max_q        <= SYNC_MAX_RST;
			lost_tick_limit_q <= LOST_TICK_LIMIT_RST;
			lost_time_limit_q <= LOST_TIME_LIMIT_RST;
			tick_period_q     <= TICK_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (pfd_reg_t'(cfg_idx))
				REG_SYNC_MIN:        sync_min_q        <= cfg_data[INTERVAL_W-1:0];
				REG_SYNC_MAX:        sync_max_q        <= cfg_data[INTERVAL_W-1:0];
				REG_LOST_TICK_LIMIT: lost_tick_limit_q <= cfg_data[TICKS_W-1:0];
				REG_LOST_TIME_LIMIT: lost_time_limit_q <= cfg_data[ELAPSED_W-1:0];
				REG_TICK_PERIOD:     tick_period_q     <= cfg_data[INTERVAL_W-1:0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// A sync gap lies strictly inside the window; an inverted window never matches.
	assign gap = (interval_s1 > sync_min_q) && (interval_s1 < sync_max_q);

	// Elapsed time since sync, saturating.
	assign add_term    = (mode_s1 == MODE_TICK) ? tick_period_q : interval_s1;
	assign elapsed_sum = {1'b0, elapsed_q} + {{(ELAPSED_W+1-INTERVAL_W){1'b0}}, add_term};
	assign elapsed_sat = elapsed_sum[ELAPSED_W] ? ELAPSED_SAT : elapsed_sum[ELAPSED_W-1:0];

	assign pulses_less_one = pulse_count_q - COUNT_W'(1);

	always_comb begin
		det_n    = in_detect_q;
		pc_n     = pulse_count_q;
		cc_n     = channel_count_q;
		lt_n     = lost_ticks_q;
		el_n     = elapsed_sat;
		vvalid_n = 1'b0;
		index_n  = '0;
		value_n  = '0;
		fsync_n  = 1'b0;

		if (mode_s1 == MODE_TICK) begin
			if (lost_ticks_q != TICKS_SAT) begin
				lt_n = lost_ticks_q + TICKS_W'(1);
			end
		end else begin
			// An over-long gap drops the channel count and restarts detection.
			if (interval_s1 > sync_max_q) begin
				pc_n  = '0;
				cc_n  = '0;
				det_n = 1'b1;
			end
			if (det_n) begin
				if (gap) begin
					if (pc_n != '0) begin
						if (pulses_less_one > MAX_CH) begin
							pc_n = COUNT_W'(1);  // too many pulses: count again from this gap
						end else begin
							cc_n  = pulses_less_one;
							det_n = 1'b0;
							lt_n  = '0;
							pc_n  = '0;
						end
					end else begin
						pc_n = COUNT_W'(1);
					end
				end else if ((interval_s1 < sync_min_q) && (pc_n != '0)) begin
					if (pc_n != PULSE_SAT) begin
						pc_n = pc_n + COUNT_W'(1);
					end
				end
			end else begin
				if (gap) begin
					pc_n    = '0;
					el_n    = '0;
					fsync_n = 1'b1;
				end else if (pc_n < cc_n) begin
					vvalid_n = 1'b1;
					index_n  = pc_n[INDEX_W-1:0];
					value_n  = interval_s1;
					pc_n     = pc_n + COUNT_W'(1);
				end else begin
					// Extra pulse in the frame: lose lock and detect again.
					det_n = 1'b1;
					el_n  = '0;
				end
			end
		end

		// Link status after the update.
		if ((lt_n == '0) && (cc_n != '0) && !det_n) begin
			link_n = LINK_OK;
		end else if ((lt_n < lost_tick_limit_q) && (cc_n != '0) &&
				(!det_n || (el_n < lost_time_limit_q))) begin
			link_n = LINK_LOST;
		end else begin
			link_n = LINK_REALLY_LOST;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			mode_s1     <= in_ch.mode;
			interval_s1 <= in_ch.interval;
		end
	end

	// State update and result valid, once per beat leaving the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_detect_q     <= 1'b1;
			pulse_count_q   <= '0;
			channel_count_q <= '0;
			lost_ticks_q    <= '0;
			elapsed_q       <= ELAPSED_SAT;
			valid_s2        <= 1'b0;
		end else begin
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (advance && valid_s1) begin
				in_detect_q     <= det_n;
				pulse_count_q   <= pc_n;
				channel_count_q <= cc_n;
				lost_ticks_q    <= lt_n;
				elapsed_q       <= el_n;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			link_s2   <= link_n;
			detect_s2 <= det_n;
			total_s2  <= cc_n;
			vvalid_s2 <= vvalid_n;
			index_s2  <= index_n;
			value_s2  <= value_n;
			fsync_s2  <= fsync_n;
		end
	end

	assign out_ch.valid         = valid_s2;
	assign out_ch.link_status   = link_s2;
	assign out_ch.detecting     = detect_s2;
	assign out_ch.channel_total = total_s2;
	assign out_ch.value_valid   = vvalid_s2;
	assign out_ch.channel_index = index_s2;
	assign out_ch.channel_value = value_s2;
	assign out_ch.frame_sync    = fsync_s2;

	// A decoded value only comes out while decoding, below the channel count.
	a_value_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && vvalid_s2) |->
			(!detect_s2 && ({1'b0, index_s2} < total_s2)))
		else $error("decoded channel outside detected range");

	// Frame sync and a channel value never share a beat, and sync implies decoding.
	a_sync_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && fsync_s2) |-> (!vvalid_s2 && !detect_s2))
		else $error("frame sync with value or in detection");

	// Decoding always runs with a channel count no larger than the limit.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!in_detect_q |-> (channel_count_q <= MAX_CH))
		else $error("channel count above limit while decoding");

	// A stalled input beat leaves the decoder state untouched.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(pulse_count_q) && $stable(elapsed_q) &&
			$stable(in_detect_q)))
		else $error("decoder state moved during stall");

endmodule

@@ tb/ppm_frame_decoder_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM frame decoder checker
// Watches the configuration port and both channels, keeps its own copy of the
// decoder state, predicts one result per input beat and compares every result
// beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ppm_frame_decoder_checker
	import pfd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pfd_in_if                     in_mon,
	pfd_out_if                    out_mon,
	output int                    fail_count,
	output int                    backlog
);

	typedef struct packed {
		pfd_link_t             link_status;
		logic                  detecting;
		logic [COUNT_W-1:0]    channel_total;
		logic                  value_valid;
		logic [INDEX_W-1:0]    channel_index;
		logic [INTERVAL_W-1:0] channel_value;
		logic                  frame_sync;
	} pfd_result_t;

	localparam logic [ELAPSED_W-1:0] ELAPSED_SAT = '1;

	// register copies
	logic [INTERVAL_W-1:0] sync_min_r, sync_max_r, tick_period_r;
	logic [TICKS_W-1:0]    tick_limit_r;
	logic [ELAPSED_W-1:0]  time_limit_r;

	// decoder state copies
	logic                  in_detect;
	logic [COUNT_W-1:0]    pulses;
	logic [COUNT_W-1:0]    channels;
	logic [TICKS_W-1:0]    ticks;
	logic [ELAPSED_W-1:0]  elapsed;

	pfd_result_t predicted_beats[$];
	int errors = 0;
	int beat_no = 0;

	assign fail_count = errors;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
				beat_no, name, got, want));
	endtask

	function automatic logic [ELAPSED_W-1:0] sat_add(input logic [ELAPSED_W-1:0] a,
			input logic [INTERVAL_W-1:0] d);
		logic [ELAPSED_W:0] s;
		s = {1'b0, a} + {{(ELAPSED_W+1-INTERVAL_W){1'b0}}, d};
		return s[ELAPSED_W] ? ELAPSED_SAT : s[ELAPSED_W-1:0];
	endfunction

	// Advance the decoder copy by one beat and build the result it yields.
	task automatic step_decoder(input pfd_mode_t mode, input logic [INTERVAL_W-1:0] dt,
			output pfd_result_t r);
		logic gap;
		r = '0;
		if (mode == MODE_TICK) begin
			if (ticks != '1)
				ticks++;
			elapsed = sat_add(elapsed, tick_period_r);
		end else begin
			gap = dt > sync_min_r && dt < sync_max_r;
			elapsed = sat_add(elapsed, dt);
			if (dt > sync_max_r) begin
				pulses    = '0;
				channels  = '0;
				in_detect = 1'b1;
			end
			if (in_detect) begin
				if (gap) begin
					if (pulses != '0) begin
						if (int'(pulses) - 1 > CHAN_LIMIT) begin
							pulses = COUNT_W'(1);
						end else begin
							channels  = pulses - COUNT_W'(1);
							in_detect = 1'b0;
							ticks     = '0;
							pulses    = '0;
						end
					end else begin
						pulses = COUNT_W'(1);
					end
				end else if (dt < sync_min_r && pulses != '0) begin
					if (pulses != '1)
						pulses++;
				end
			end else begin
				if (gap) begin
					pulses      = '0;
					elapsed     = '0;
					r.frame_sync = 1'b1;
				end else if (pulses < channels) begin
					r.value_valid   = 1'b1;
					r.channel_index = pulses[INDEX_W-1:0];
					r.channel_value = dt;
					pulses++;
				end else begin
					in_detect = 1'b1;
					elapsed   = '0;
				end
			end
		end

		if (ticks == '0 && channels != '0 && !in_detect)
			r.link_status = LINK_OK;
		else if (ticks < tick_limit_r && channels != '0
				&& (!in_detect || elapsed < time_limit_r))
			r.link_status = LINK_LOST;
		else
			r.link_status = LINK_REALLY_LOST;
		r.detecting     = in_detect;
		r.channel_total = channels;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pfd_result_t want;
		if (!arst_n) begin
			sync_min_r    = SYNC_MIN_RST;
			sync_max_r    = SYNC_MAX_RST;
			tick_limit_r  = LOST_TICK_LIMIT_RST;
			time_limit_r  = LOST_TIME_LIMIT_RST;
			tick_period_r = TICK_PERIOD_RST;
			in_detect     = 1'b1;
			pulses        = '0;
			channels      = '0;
			ticks         = '0;
			elapsed       = ELAPSED_SAT;
			predicted_beats.delete();
			backlog <= 0;
		end else begin
			// compare first: a result never belongs to a beat taken at the same edge
			if (out_mon.valid && out_mon.ready) begin
				if (predicted_beats.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with nothing expected",
						beat_no));
				end else begin
					want = predicted_beats.pop_front();
					check_field("link_status", out_mon.link_status, want.link_status);
					check_field("detecting", out_mon.detecting, want.detecting);
					check_field("channel_total", out_mon.channel_total, want.channel_total);
					check_field("value_valid", out_mon.value_valid, want.value_valid);
					check_field("channel_index", out_mon.channel_index, want.channel_index);
					check_field("channel_value", out_mon.channel_value, want.channel_value);
					check_field("frame_sync", out_mon.frame_sync, want.frame_sync);
				end
				beat_no++;
			end
			if (cfg_we) begin
				case (pfd_reg_t'(cfg_idx))
					REG_SYNC_MIN:        sync_min_r    = cfg_data[INTERVAL_W-1:0];
					REG_SYNC_MAX:        sync_max_r    = cfg_data[INTERVAL_W-1:0];
					REG_LOST_TICK_LIMIT: tick_limit_r  = cfg_data[TICKS_W-1:0];
					REG_LOST_TIME_LIMIT: time_limit_r  = cfg_data[ELAPSED_W-1:0];
					REG_TICK_PERIOD:     tick_period_r = cfg_data[INTERVAL_W-1:0];
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready) begin
				step_decoder(pfd_mode_t'(in_mon.mode), in_mon.interval, want);
				predicted_beats.push_back(want);
			end
			backlog <= predicted_beats.size();
		end
	end

endmodule

@@ tb/tb_ppm_frame_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM frame decoder core testbench
// Drives edge intervals and timeout ticks into the decoder under several sync
// windows and loss limits: a short directed sequence first, then randomized
// PPM frames mixed with noise, ticks and broken frames. A checker beside the
// decoder predicts and compares every result beat; this module only makes
// stimulus, throttles both channels and gives the verdict.
// ----------------------------------------------------------------------------
module tb_ppm_frame_decoder_core;
	import pfd_pkg::*;

	// Cycles without any beat on either channel before the run is declared hung.
	// The slowest legal stretch is a sender gap plus a sink stall plus the
	// trip through the input and result registers.
	localparam int IDLE_LIMIT  = 2000;
	// Settle time after the last result, with margin.
	localparam int TAIL_CYCLES = 8;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	pfd_in_if  in_ch();
	pfd_out_if out_ch();

	int fail_count;
	int backlog;

	// calm: no idling on either side (final part of the run)
	bit calm = 1'b0;
	int calm_left = 0;
	int sent = 0;
	int idle_cycles = 0;

	// sync window as currently programmed, used to shape frames
	logic [INTERVAL_W-1:0] gap_lo;
	logic [INTERVAL_W-1:0] gap_hi;

	ppm_frame_decoder_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	ppm_frame_decoder_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_mon    (in_ch),
		.out_mon   (out_ch),
		.fail_count(fail_count),
		.backlog   (backlog)
	);

	always #5 clk = ~clk;

	// Watchdog: reset the count on any beat, give up when the design hangs.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_ppm_frame_decoder_core NOT OK");
			$finish;
		end
	end

	// Result sink: stall now and then, with stall-free stretches
	// in between, and never once the run has gone calm.
	initial begin : sink
		int run_left;
		run_left = 0;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (calm || run_left > 0) begin
				out_ch.ready <= 1'b1;
				if (run_left > 0)
					run_left--;
			end else begin
				case ($urandom_range(0, 7))
					0, 1: begin
						out_ch.ready <= 1'b0;
						repeat ($urandom_range(1, 5)) @(posedge clk);
						out_ch.ready <= 1'b1;
					end
					2: run_left = $urandom_range(20, 60);
					default: out_ch.ready <= 1'b1;
				endcase
			end
		end
	end

	function automatic logic [INTERVAL_W-1:0] rand_interval();
		return INTERVAL_W'($urandom_range(0, 65535));
	endfunction

	// Offer one beat and hold it until taken. Valid stays high when the next
	// beat follows directly; drop it only for a gap.
	task automatic send_beat(input pfd_mode_t mode, input logic [INTERVAL_W-1:0] dt);
		in_ch.valid    <= 1'b1;
		in_ch.mode     <= mode;
		in_ch.interval <= dt;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sent++;
		if (calm_left > 0) begin
			calm_left--;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end else if ($urandom_range(0, 29) == 0) begin
			calm_left = $urandom_range(15, 40);
		end
	endtask

	task automatic send_tick();
		// interval is don't-care on a tick; keep it random so its bits toggle
		send_beat(MODE_TICK, rand_interval());
	endtask

	// Hold off the sender until every predicted result has been delivered.
	// Sample after an edge first so a beat taken at this very edge is counted.
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (backlog != 0);
	endtask

	task automatic put_reg(input pfd_reg_t r, input logic [CFG_DATA_W-1:0] v);
		cfg_we   <= 1'b1;
		cfg_idx  <= r;
		cfg_data <= v;
		@(posedge clk);
	endtask

	// Program all five registers once the decoder is idle.
	task automatic set_config(input int sync_min, input int sync_max, input int tick_lim,
			input int time_lim, input int tick_per);
		drain_results();
		put_reg(REG_SYNC_MIN, CFG_DATA_W'(sync_min));
		put_reg(REG_SYNC_MAX, CFG_DATA_W'(sync_max));
		put_reg(REG_LOST_TICK_LIMIT, CFG_DATA_W'(tick_lim));
		put_reg(REG_LOST_TIME_LIMIT, CFG_DATA_W'(time_lim));
		put_reg(REG_TICK_PERIOD, CFG_DATA_W'(tick_per));
		cfg_we <= 1'b0;
		gap_lo = INTERVAL_W'(sync_min);
		gap_hi = INTERVAL_W'(sync_max);
	endtask

	// Channel pulse: below sync_min, now and then exactly on it; random when sync_min is zero.
	function automatic logic [INTERVAL_W-1:0] pick_pulse();
		int lo;
		lo = gap_lo;
		if (lo == 0)
			return rand_interval();
		if ($urandom_range(0, 15) == 0)
			return gap_lo;
		return INTERVAL_W'($urandom_range(0, lo - 1));
	endfunction

	// Sync gap strictly inside the window; random when the window is empty.
	function automatic logic [INTERVAL_W-1:0] pick_sync();
		int lo, hi;
		lo = gap_lo;
		hi = gap_hi;
		if (hi - lo < 2)
			return rand_interval();
		return INTERVAL_W'($urandom_range(lo + 1, hi - 1));
	endfunction

	// Well-formed stream: a leading sync, then 1 to 4 frames of the same
	// channel count. Counts cover zero, the maximum, just above it and enough
	// pulses to saturate the detector's counter.
	task automatic send_frames();
		int chans;
		case ($urandom_range(0, 11))
			0: chans = 0;
			1: chans = CHAN_LIMIT;
			2: chans = $urandom_range(CHAN_LIMIT + 1, CHAN_LIMIT + 4);
			3: chans = $urandom_range(30, 33);
			default: chans = $urandom_range(1, 8);
		endcase
		send_beat(MODE_EDGE, pick_sync());
		repeat ($urandom_range(1, 4)) begin
			repeat (chans) send_beat(MODE_EDGE, pick_pulse());
			send_beat(MODE_EDGE, pick_sync());
		end
	endtask

	// Noise and broken frames between the well-formed ones.
	task automatic disturb();
		case ($urandom_range(0, 4))
			0: repeat ($urandom_range(1, 6)) send_tick();
			1: repeat ($urandom_range(1, 4)) send_beat(MODE_EDGE, rand_interval());
			2: begin
				// over-long gap forces re-detection where the window allows it
				if (gap_hi != '1)
					send_beat(MODE_EDGE, INTERVAL_W'($urandom_range(int'(gap_hi) + 1, 65535)));
				else
					send_beat(MODE_EDGE, rand_interval());
			end
			3: begin
				send_beat(MODE_EDGE, gap_lo);
				send_beat(MODE_EDGE, gap_hi);
			end
			default: send_beat(MODE_EDGE, pick_pulse());
		endcase
	endtask

	task automatic run_traffic(input int n_items);
		int stop;
		stop = sent + n_items;
		while (sent < stop) begin
			if ($urandom_range(0, 9) < 7)
				send_frames();
			else
				disturb();
		end
	endtask

	initial begin : stimulus
		int sm;
		in_ch.valid    <= 1'b0;
		in_ch.mode     <= MODE_EDGE;
		in_ch.interval <= '0;
		cfg_we         <= 1'b0;
		cfg_idx        <= REG_SYNC_MIN;
		cfg_data       <= '0;
		arst_n         <= 1'b0;
		gap_lo = SYNC_MIN_RST;
		gap_hi = SYNC_MAX_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part, reset register values (sync window 600..1500) ----
		send_tick();                           // tick straight out of reset
		send_beat(MODE_EDGE, 16'd0);           // smallest interval, no sync seen yet: ignored
		send_beat(MODE_EDGE, 16'hFFFF);        // largest interval: above sync_max, re-detect
		send_beat(MODE_EDGE, 16'd1000);        // first sync gap opens the count
		repeat (3) send_beat(MODE_EDGE, 16'd300);
		send_beat(MODE_EDGE, SYNC_MIN_RST);    // on sync_min: neither gap nor pulse
		send_beat(MODE_EDGE, SYNC_MAX_RST);    // on sync_max: ignored, no re-detect
		send_beat(MODE_EDGE, 16'd1000);        // second gap: three channels, decode
		send_beat(MODE_EDGE, 16'd0);           // channel values, zero included
		send_beat(MODE_EDGE, 16'd400);
		send_beat(MODE_EDGE, 16'd599);
		send_beat(MODE_EDGE, 16'd1000);        // frame sync in decode mode
		send_beat(MODE_EDGE, SYNC_MIN_RST);    // on sync_min in decode: treated as a pulse
		send_tick();                           // lost while decoding
		send_beat(MODE_EDGE, 16'd300);
		send_beat(MODE_EDGE, 16'd300);
		send_beat(MODE_EDGE, 16'd300);         // pulse beyond the count: back to detect
		send_beat(MODE_EDGE, 16'hFFFF);        // clear the count
		send_beat(MODE_EDGE, 16'd1000);        // two adjacent gaps: zero channels
		send_beat(MODE_EDGE, 16'd1000);
		send_beat(MODE_EDGE, 16'd300);         // any pulse leaves zero-channel decode
		send_tick();

		// ---- widest limits, longest tick period; saturate the tick count ----
		set_config(SYNC_MIN_RST, SYNC_MAX_RST, 255, 262143, 65535);
		run_traffic(30);
		repeat (260) send_tick();
		run_traffic(30);

		// ---- smallest limits, zero tick period, window open to nearly all ----
		set_config(0, 65535, 1, 1, 0);
		run_traffic(80);

		// ---- inverted window: nothing is a sync gap ----
		set_config(2000, 1000, $urandom_range(1, 255), $urandom_range(1, 262143),
			$urandom_range(0, 65535));
		run_traffic(60);

		// ---- random wide window ----
		sm = $urandom_range(50, 1500);
		set_config(sm, sm + $urandom_range(2, 4000), $urandom_range(1, 255),
			$urandom_range(1, 262143), $urandom_range(0, 65535));
		run_traffic(100);

		// ---- narrowest usable window: a single sync value ----
		sm = $urandom_range(50, 3000);
		set_config(sm, sm + 2, $urandom_range(1, 255), $urandom_range(1, 262143),
			$urandom_range(0, 65535));
		run_traffic(100);

		// ---- back to reset values, no idling on either side ----
		set_config(SYNC_MIN_RST, SYNC_MAX_RST, LOST_TICK_LIMIT_RST, LOST_TIME_LIMIT_RST,
			TICK_PERIOD_RST);
		calm = 1'b1;
		run_traffic(90);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && backlog == 0)
			$display("tb_ppm_frame_decoder_core OK");
		else
			$display("tb_ppm_frame_decoder_core NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/pfd_pkg.sv
hw/rtl/pfd_in_if.sv
hw/rtl/pfd_out_if.sv
hw/rtl/ppm_frame_decoder_core.sv
tb/ppm_frame_decoder_checker.sv
tb/tb_ppm_frame_decoder_core.sv
